FILE: sv/dqr_pkg.sv
package dqr_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_TAKE_INS
  } cell_sel_e;

  typedef struct packed {
    cell_sel_e                 sel;
    logic signed [DATA_W-1:0]  ins;
  } cell_ctl_t;

endpackage

FILE: sv/dqr_cell.sv
module dqr_cell (
  input  logic                                 clk_i,
  input  dqr_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [dqr_pkg::DATA_W-1:0]    left_i,
  input  logic signed [dqr_pkg::DATA_W-1:0]    right_i,
  output logic signed [dqr_pkg::DATA_W-1:0]    data_o
);
  import dqr_pkg::*;

  logic signed [DATA_W-1:0] data_q;
  logic signed [DATA_W-1:0] data_d;

  always_comb begin
    case (ctl_i.sel)
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      CELL_TAKE_INS:   data_d = ctl_i.ins;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: sv/double_ended_queue_ring_unit.sv
// Channel  | valid        | ready        | payload
// request  | in_valid_i   | in_ready_o   | operation_i, value_i
// result   | out_valid_o  | out_ready_i  | item_value_o, is_last_o, status_o
//
// Values sit in cells, front in cell 0; front pushes and pops shift the row.
// Push and pop give one result each; they go back to back while results are taken.
// Dump: after accept, the row rotates one cell per free result slot, emitting cell 0.
// The result register takes a new result while the old one is being taken.
// Reset empties the queue; cell contents are not cleared.
module double_ended_queue_ring_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         operation_i,
  input  logic signed [dqr_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [dqr_pkg::DATA_W-1:0]  item_value_o,
  output logic                               is_last_o,
  output logic [1:0]                         status_o
);
  import dqr_pkg::*;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  cell_ctl_t                cell_ctl  [DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] dump_rem_q, dump_rem_d;
  logic             dumping_q, dumping_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] item_value_q, item_value_d;
  logic                     is_last_q, is_last_d;
  logic [1:0]               status_q, status_d;

  logic out_slot;
  logic in_fire;
  logic is_full;
  logic is_empty;
  logic do_push_front, do_push_back, do_pop_front, do_rotate;

  assign out_slot   = !out_valid_q || out_ready_i;
  assign in_ready_o = !dumping_q && out_slot;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CNT_W'(DEPTH));
  assign is_empty   = (count_q == '0);

  always_comb begin
    count_d       = count_q;
    dump_rem_d    = dump_rem_q;
    dumping_d     = dumping_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    item_value_d  = item_value_q;
    is_last_d     = is_last_q;
    status_d      = status_q;
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    do_rotate     = 1'b0;

    if (dumping_q && out_slot) begin
      do_rotate    = 1'b1;
      out_valid_d  = 1'b1;
      item_value_d = cell_data[0];
      status_d     = ST_OK;
      is_last_d    = (dump_rem_q == CNT_W'(1));
      dump_rem_d   = dump_rem_q - CNT_W'(1);
      dumping_d    = (dump_rem_q != CNT_W'(1));
    end else if (in_fire) begin
      item_value_d = '0;
      is_last_d    = 1'b1;
      unique case (operation_i) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          out_valid_d = 1'b1;
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            status_d      = ST_OK;
            count_d       = count_q + CNT_W'(1);
            do_push_front = (operation_i == OP_PUSH_FRONT);
            do_push_back  = (operation_i == OP_PUSH_BACK);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          out_valid_d = 1'b1;
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            status_d     = ST_OK;
            count_d      = count_q - CNT_W'(1);
            do_pop_front = (operation_i == OP_POP_FRONT);
          end
        end
        OP_DUMP: begin
          if (is_empty) begin
            out_valid_d = 1'b1;
            status_d    = ST_EMPTY;
          end else begin
            dumping_d  = 1'b1;
            dump_rem_d = count_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].sel = CELL_HOLD;
      cell_ctl[i].ins = do_rotate ? cell_data[0] : value_i;
      if (do_push_front) begin
        cell_ctl[i].sel = CELL_TAKE_LEFT;
      end else if (do_pop_front) begin
        cell_ctl[i].sel = CELL_TAKE_RIGHT;
      end else if (do_push_back) begin
        if (count_q[IDX_W-1:0] == IDX_W'(i)) begin
          cell_ctl[i].sel = CELL_TAKE_INS;
        end
      end else if (do_rotate) begin
        if (CNT_W'(i) + CNT_W'(1) == count_q) begin
          cell_ctl[i].sel = CELL_TAKE_INS;
        end else if (CNT_W'(i) + CNT_W'(1) < count_q) begin
          cell_ctl[i].sel = CELL_TAKE_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    dqr_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dump_rem_q  <= '0;
      dumping_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dump_rem_q  <= dump_rem_d;
      dumping_q   <= dumping_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_value_q <= item_value_d;
    is_last_q    <= is_last_d;
    status_q     <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign item_value_o = item_value_q;
  assign is_last_o    = is_last_q;
  assign status_o     = status_q;

endmodule

FILE: tb/tb_double_ended_queue_ring_unit.sv
`timescale 1ns / 100ps

module tb_double_ended_queue_ring_unit;
  import dqr_pkg::*;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TARGET_REQUESTS = 210;
  localparam int unsigned N_DIR = 23;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic signed [DATA_W-1:0] item_value;
    logic                     is_last;
    logic [1:0]               status;
  } deque_result_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] value;
    logic              typed;
    logic              has_res;
    logic [1:0]        status;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               operation_i = OP_PUSH_FRONT;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] item_value_o;
  logic                     is_last_o;
  logic [1:0]               status_o;

  double_ended_queue_ring_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_value_o (item_value_o),
    .is_last_o    (is_last_o),
    .status_o     (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // deque shadow
  logic signed [DATA_W-1:0] deque_mem [DEPTH];
  logic [IDX_W-1:0]         front_slot = '0;
  logic [CNT_W-1:0]         stored_cnt = '0;

  deque_result_t step_results [$];
  deque_result_t pending_results [$];

  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_dumps = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, ST_EMPTY},
    '{OP_POP_BACK,   32'hffff_ffff, 1'b1, 1'b1, ST_EMPTY},
    '{OP_DUMP,       32'h0000_0000, 1'b1, 1'b1, ST_EMPTY},
    '{OP_SPARE_5,    32'h1234_5678, 1'b1, 1'b0, ST_OK},
    '{OP_PUSH_FRONT, 32'h7fff_ffff, 1'b1, 1'b1, ST_OK},
    '{OP_PUSH_BACK,  32'h8000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_PUSH_FRONT, 32'hffff_ffff, 1'b1, 1'b1, ST_OK},
    '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_DUMP,       32'h5a5a_5a5a, 1'b0, 1'b0, ST_OK},
    '{OP_SPARE_6,    32'h5555_5555, 1'b1, 1'b0, ST_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_DUMP,       32'h0000_0000, 1'b0, 1'b0, ST_OK},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_SPARE_7,    32'haaaa_aaaa, 1'b1, 1'b0, ST_OK},
    '{OP_PUSH_BACK,  32'h1234_5678, 1'b1, 1'b1, ST_OK},
    '{OP_DUMP,       32'h0000_0000, 1'b0, 1'b0, ST_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, 1'b1, ST_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, ST_EMPTY},
    '{OP_DUMP,       32'h0000_0000, 1'b1, 1'b1, ST_EMPTY},
    '{OP_PUSH_FRONT, 32'h0000_0001, 1'b1, 1'b1, ST_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, ST_OK}
  };

  function automatic deque_result_t mk_result(input logic signed [DATA_W-1:0] v,
                                              input logic l, input logic [1:0] s);
    deque_result_t r;
    r.item_value = v;
    r.is_last    = l;
    r.status     = s;
    return r;
  endfunction

  function automatic void deque_apply(input logic [2:0] op,
                                      input logic signed [DATA_W-1:0] val);
    int unsigned slot;
    step_results.delete();
    case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (stored_cnt >= DEPTH) begin
          step_results.push_back(mk_result('0, 1'b1, ST_FULL));
        end else begin
          if (op == OP_PUSH_FRONT) begin
            front_slot = (front_slot == 0) ? IDX_W'(DEPTH - 1) : front_slot - 1'b1;
            deque_mem[front_slot] = val;
          end else begin
            deque_mem[(front_slot + stored_cnt) % DEPTH] = val;
          end
          stored_cnt = stored_cnt + 1'b1;
          step_results.push_back(mk_result('0, 1'b1, ST_OK));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (stored_cnt == 0) begin
          step_results.push_back(mk_result('0, 1'b1, ST_EMPTY));
        end else begin
          if (op == OP_POP_FRONT) begin
            front_slot = IDX_W'((front_slot + 1) % DEPTH);
          end
          stored_cnt = stored_cnt - 1'b1;
          step_results.push_back(mk_result('0, 1'b1, ST_OK));
        end
      end
      OP_DUMP: begin
        if (stored_cnt == 0) begin
          step_results.push_back(mk_result('0, 1'b1, ST_EMPTY));
        end else begin
          slot = front_slot;
          for (int unsigned i = 0; i < stored_cnt; i++) begin
            step_results.push_back(mk_result(deque_mem[slot], (i + 1 == stored_cnt),
                                             ST_OK));
            slot = (slot + 1) % DEPTH;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h7fff_ffff;
    if (r < 16) return 32'h8000_0000;
    if (r < 20) return 32'h0000_0000;
    if (r < 24) return 32'hffff_ffff;
    return $urandom();
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [DATA_W-1:0] val,
                              input logic typed, input logic has_res,
                              input logic [1:0] st);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
    deque_apply(op, val);
    if (op <= OP_DUMP) n_requests++;
    if (op == OP_DUMP) n_dumps++;
    if (typed) begin
      step_results.delete();
      if (has_res) step_results.push_back(mk_result('0, 1'b1, st));
    end
    foreach (step_results[i]) begin
      if (step_results[i].status == ST_FULL) n_full++;
      if (step_results[i].status == ST_EMPTY) n_empty++;
      pending_results.push_back(step_results[i]);
    end
  endtask

  task automatic send_push();
    send_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(),
                 1'b0, 1'b0, ST_OK);
  endtask

  task automatic send_pop();
    send_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value(),
                 1'b0, 1'b0, ST_OK);
  endtask

  task automatic fill_block();
    int unsigned extra;
    extra = $urandom_range(1, 3);
    while (stored_cnt < DEPTH) send_push();
    repeat (extra) send_push();
    send_request(OP_DUMP, pick_value(), 1'b0, 1'b0, ST_OK);
  endtask

  task automatic drain_block();
    int unsigned extra;
    extra = $urandom_range(1, 2);
    while (stored_cnt != 0) send_pop();
    repeat (extra) send_pop();
    send_request(OP_DUMP, pick_value(), 1'b0, 1'b0, ST_OK);
  endtask

  task automatic mixed_block();
    int unsigned len;
    int unsigned r;
    len = $urandom_range(6, 14);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_push();
      else if (r < 80) send_pop();
      else if (r < 92) send_request(OP_DUMP, pick_value(), 1'b0, 1'b0, ST_OK);
      else send_request(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), pick_value(),
                        1'b0, 1'b0, ST_OK);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left  <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    deque_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: value %h last %b status %0d",
                   item_value_o, is_last_o, status_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (item_value_o !== exp_res.item_value || is_last_o !== exp_res.is_last ||
            status_o !== exp_res.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result %0d: expected value %h last %b status %0d, got %h %b %0d",
                     n_results, exp_res.item_value, exp_res.is_last, exp_res.status,
                     item_value_o, is_last_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < N_DIR; i++)
      send_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                   dir_rows[i].has_res, dir_rows[i].status);

    // hold off until the result side has caught up
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    steady = 1'b0;
    fill_block();
    while (n_requests < TARGET_REQUESTS) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0 && stored_cnt > 16) fill_block();
      else if (kind == 1) drain_block();
      else mixed_block();
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests: %0d dumps, %0d refused pushes, %0d empty-queue hits.",
             n_requests, n_dumps, n_full, n_empty);
    $display("Checked %0d results, %0d mismatches.", n_results, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
